@@ rtl/core/swfrm_pkg.sv @@
package swfrm_pkg;

   localparam logic [31:0] WINDOW_RESET_MS = 32'd60000;
   localparam logic [31:0] ROLL_ARM_MS     = 32'd3000000000;
   localparam logic [31:0] ROLL_FALL_MS    = 32'd100000;
   localparam logic [15:0] ROLL_DAYS       = 16'd50;
   localparam logic [15:0] DAYS_MAX        = 16'hffff;
   localparam logic [5:0]  FPM_MAX         = 6'd63;

   typedef struct packed {
      logic [31:0] time_ms;
      logic [7:0]  frame_count;
   } req_payload_type;

   typedef struct packed {
      logic [5:0]  frames_per_minute;
      logic [31:0] received_total;
      logic [15:0] uptime_days;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_FLUSH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear;
      logic start;
      logic read;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic out_free;
   } status_type;

endpackage

@@ rtl/core/swfrm_ram.sv @@
module swfrm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/swfrm_ctrl.sv @@
module swfrm_ctrl
   import swfrm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (status.last) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.start = req_valid;
         end
         ST_WALK: begin
            cmd.read = 1'b1;
         end
         ST_FLUSH: begin
         end
         ST_FINISH: begin
            cmd.finish = status.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

@@ rtl/core/swfrm_datapath.sv @@
module swfrm_datapath
   import swfrm_pkg::*;
#(
   parameter int SLOTS = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   output status_type      status,
   input  req_payload_type req_payload,
   input  logic            csr_write,
   input  logic [31:0]     csr_data,
   input  logic            rsp_ready,
   output logic            rsp_valid,
   output rsp_payload_type rsp_payload
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int OCC_W = $clog2(SLOTS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   logic [31:0]      window_ff, window_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0] rd_addr_ff, rd_addr_in;
   logic [31:0]      now_ff, now_in;
   logic [7:0]       left_ff, left_in;
   logic             expire_en_ff, expire_en_in;
   logic [31:0]      limit_ff, limit_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic [31:0]      total_ff, total_in;
   logic             armed_ff, armed_in;
   logic [15:0]      day_ff, day_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_payload_ff, rsp_payload_in;

   logic [31:0] rd_data;
   logic [31:0] slot_val;
   logic        place;
   logic        wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [31:0] wr_data;
   logic        armed_next;
   logic [16:0] day_sum;

   swfrm_ram #(
      .WIDTH (32),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.read),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      slot_val = rd_data;
      if (expire_en_ff && (rd_data < limit_ff)) begin
         slot_val = '0;
      end
      place = (left_ff != 8'd0) && (slot_val == 32'd0);
      if (place) begin
         slot_val = now_ff;
      end
   end

   assign wr_en   = cmd.clear | rd_pend_ff;
   assign wr_addr = cmd.clear ? idx_ff : rd_addr_ff;
   assign wr_data = cmd.clear ? 32'd0 : slot_val;

   assign armed_next = armed_ff | (req_payload.time_ms >= ROLL_ARM_MS);
   assign day_sum    = {1'b0, day_ff} + {1'b0, ROLL_DAYS};

   always_comb begin
      window_in    = window_ff;
      idx_in       = idx_ff;
      rd_pend_in   = cmd.read;
      rd_addr_in   = idx_ff;
      now_in       = now_ff;
      left_in      = left_ff;
      expire_en_in = expire_en_ff;
      limit_in     = limit_ff;
      occ_in       = occ_ff;
      total_in     = total_ff;
      armed_in     = armed_ff;
      day_in       = day_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;

      if (csr_write) begin
         window_in = csr_data;
      end

      if (cmd.clear || cmd.read) begin
         idx_in = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
      end

      if (cmd.start) begin
         idx_in       = '0;
         now_in       = req_payload.time_ms;
         left_in      = req_payload.frame_count;
         expire_en_in = req_payload.time_ms > window_ff;
         limit_in     = req_payload.time_ms - window_ff;
         occ_in       = '0;
         total_in     = total_ff + 32'(req_payload.frame_count);
         armed_in     = armed_next;
         if ((req_payload.time_ms <= ROLL_FALL_MS) && armed_next) begin
            day_in   = (day_sum > {1'b0, DAYS_MAX}) ? DAYS_MAX : day_sum[15:0];
            armed_in = 1'b0;
         end
      end

      if (rd_pend_ff) begin
         if (place) begin
            left_in = left_ff - 8'd1;
         end
         if (slot_val != 32'd0) begin
            occ_in = occ_ff + 1'b1;
         end
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_payload_in.frames_per_minute =
            (32'(occ_ff) > 32'(FPM_MAX)) ? FPM_MAX : 6'(occ_ff);
         rsp_payload_in.received_total = total_ff;
         rsp_payload_in.uptime_days    = day_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WINDOW_RESET_MS;
         idx_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         total_ff     <= '0;
         armed_ff     <= 1'b0;
         day_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         window_ff    <= window_in;
         idx_ff       <= idx_in;
         rd_pend_ff   <= rd_pend_in;
         total_ff     <= total_in;
         armed_ff     <= armed_in;
         day_ff       <= day_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff     <= rd_addr_in;
      now_ff         <= now_in;
      left_ff        <= left_in;
      expire_en_ff   <= expire_en_in;
      limit_ff       <= limit_in;
      occ_ff         <= occ_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign status.last     = (idx_ff == LAST_IDX);
   assign status.out_free = ~rsp_valid_ff | rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_payload     = rsp_payload_ff;

endmodule

@@ rtl/core/sliding_window_frame_rate_meter.sv @@
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_payload_type (time_ms, frame_count)
// rsp       out        rsp_valid/rsp_ready    rsp_payload_type (fpm, total, days)
// csr       in         csr_valid/csr_ready    csr_data = window_ms
//
// One request walks every slot of the timestamp RAM in turn: one slot is read
// and written back per cycle through its single read port.
// After reset a clearing pass over all SLOTS slots zeroes the RAM; no request is
// taken then. A result waiting in the output register does not block the next
// request; the walk stalls at its end only until that register is free.
module sliding_window_frame_rate_meter
   import swfrm_pkg::*;
#(
   parameter int SLOTS = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [31:0]     csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   swfrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   swfrm_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .csr_write   (csr_valid & csr_ready),
      .csr_data    (csr_data),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ tb/frame_rate_meter_check.sv @@
module frame_rate_meter_check
   import swfrm_pkg::*;
#(
   parameter int SLOTS = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   input  logic            csr_ready,
   input  logic [31:0]     csr_data,
   output int              mismatches,
   output int              outstanding,
   output int              checked
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [31:0]     window_ms;
   logic [31:0]     stamp_ms [SLOTS];
   logic [31:0]     frames_seen;
   logic            rollover_armed;
   logic [15:0]     days_added;
   rsp_payload_type expected_rates [$];
   int              bad_count;
   int              seen_count;

   always @(posedge clock) begin : track
      logic [31:0]     now_ms;
      int              unplaced;
      int              occupied;
      rsp_payload_type want;
      rsp_payload_type got;
      if (reset) begin
         window_ms = WINDOW_RESET_MS;
         for (int i = 0; i < SLOTS; i++) stamp_ms[i] = '0;
         frames_seen = '0;
         rollover_armed = 1'b0;
         days_added = '0;
         expected_rates.delete();
         bad_count = 0;
         seen_count = 0;
      end else begin
         if (csr_valid && csr_ready) window_ms = csr_data;

         if (rsp_valid && rsp_ready) begin
            got = rsp_payload;
            seen_count++;
            if (expected_rates.size() == 0) begin
               if (bad_count < 10)
                  $display("unexpected result: fpm %0d total %0d days %0d",
                           got.frames_per_minute, got.received_total, got.uptime_days);
               bad_count++;
            end else begin
               want = expected_rates.pop_front();
               if (got.frames_per_minute !== want.frames_per_minute ||
                   got.received_total !== want.received_total ||
                   got.uptime_days !== want.uptime_days) begin
                  if (bad_count < 10)
                     $display("result %0d (expected/actual): fpm %0d/%0d total %0d/%0d days %0d/%0d",
                              seen_count, want.frames_per_minute, got.frames_per_minute,
                              want.received_total, got.received_total,
                              want.uptime_days, got.uptime_days);
                  bad_count++;
               end
            end
         end

         if (req_valid && req_ready) begin
            now_ms = req_payload.time_ms;
            unplaced = req_payload.frame_count;
            occupied = 0;
            frames_seen = frames_seen + req_payload.frame_count;
            if (now_ms >= ROLL_ARM_MS) rollover_armed = 1'b1;
            if (now_ms <= ROLL_FALL_MS && rollover_armed) begin
               days_added = (days_added > DAYS_MAX - ROLL_DAYS) ? DAYS_MAX
                                                                : days_added + ROLL_DAYS;
               rollover_armed = 1'b0;
            end
            for (int i = 0; i < SLOTS; i++) begin
               if (now_ms > window_ms && stamp_ms[i] < now_ms - window_ms) stamp_ms[i] = '0;
               if (unplaced > 0 && stamp_ms[i] == '0) begin
                  stamp_ms[i] = now_ms;
                  unplaced--;
               end
               if (stamp_ms[i] != '0) occupied++;
            end
            want.frames_per_minute = (occupied > FPM_MAX) ? FPM_MAX : occupied[5:0];
            want.received_total = frames_seen;
            want.uptime_days = days_added;
            expected_rates.push_back(want);
         end
      end
      mismatches <= bad_count;
      outstanding <= expected_rates.size();
      checked <= seen_count;
   end

endmodule

@@ tb/tb_sliding_window_frame_rate_meter.sv @@
module tb_sliding_window_frame_rate_meter;
   import swfrm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int    SLOTS       = 32;
   localparam int    HOLD_CYCLES = 600;
   localparam int    SETTLE      = 40;
   localparam int    ROLL_PAIRS  = 40;
   localparam longint CYCLE_LIMIT = 2000000;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [31:0]     csr_data = '0;

   int          mismatches;
   int          outstanding;
   int          checked;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          hold_asked = 0;
   int          requests_sent = 0;
   int          window_writes = 0;
   longint      cycles = 0;
   logic [31:0] stim_ms = '0;

   sliding_window_frame_rate_meter #(.SLOTS(SLOTS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   frame_rate_meter_check #(.SLOTS(SLOTS)) check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .checked     (checked)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_sliding_window_frame_rate_meter failed");
         $finish;
      end
   end

   initial begin : result_sink
      int served = 0;
      int hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && served != hold_asked) begin
            served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic send(input logic [31:0] t, input logic [7:0] n);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{time_ms: t, frame_count: n};
      do @(posedge clock); while (!req_ready);
      requests_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_window(input logic [31:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      window_writes++;
   endtask

   task automatic run_phase(input int idle_pct, input int stall, input logic [31:0] win,
                            input int items, input bit hold_mid, input bit pause_mid);
      int          pick;
      logic [31:0] span;
      logic [7:0]  count;
      write_window(win);
      send_idle_pct = idle_pct;
      stall_pct = stall;
      span = win / 6 + 1;
      for (int k = 0; k < items; k++) begin
         if (k == items / 2) begin
            if (hold_mid) hold_asked++;
            if (pause_mid) drain();
         end
         pick = $urandom_range(9);
         if (pick <= 5) stim_ms = stim_ms + $urandom_range(span);
         else if (pick == 6) stim_ms = stim_ms + $urandom();
         else if (pick == 7) stim_ms = $urandom_range(3);
         else if (pick == 8) stim_ms = $urandom_range(ROLL_ARM_MS - 2, 32'hffffffff);
         else stim_ms = $urandom_range(ROLL_FALL_MS + 2);
         count = ($urandom_range(9) < 8) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
         send(stim_ms, count);
      end
   endtask

   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send(32'd0, 8'd3);
      send(32'd1000, 8'd0);
      send(32'd1000, 8'd255);
      send(32'd5000, 8'd1);
      send(32'd60999, 8'd0);
      send(32'd61001, 8'd2);
      send(32'hffffffff, 8'd0);
      send(ROLL_FALL_MS, 8'd1);
      send(ROLL_ARM_MS, 8'd0);
      send(ROLL_FALL_MS + 1, 8'd0);
      send(ROLL_ARM_MS - 1, 8'd0);
      send(32'd0, 8'd0);
      send(ROLL_FALL_MS, 8'd0);
      write_window(32'd0);
      send(32'd500, 8'd4);
      send(32'd501, 8'd1);
      send(32'd0, 8'd2);
      write_window(32'd1);
      send(32'd502, 8'd3);
      send(32'd503, 8'd0);
      write_window(32'hffffffff);
      send(32'hffffffff, 8'd255);
      send(32'hfffffffe, 8'd0);
      send(32'd1, 8'd1);

      run_phase(0, 0, WINDOW_RESET_MS, 450, 1'b1, 1'b0);
      run_phase(64, 0, $urandom_range(1, 200000), 450, 1'b0, 1'b1);
      run_phase(0, 64, $urandom_range(1, 5000), 450, 1'b0, 1'b0);
      run_phase(15, 15, $urandom(), 450, 1'b1, 1'b0);

      // repeat rollovers back to back
      write_window($urandom_range(100, 100000));
      for (int k = 0; k < ROLL_PAIRS; k++) begin
         send($urandom_range(ROLL_ARM_MS, 32'hffffffff), 8'($urandom_range(255)));
         send($urandom_range(ROLL_FALL_MS), 8'($urandom_range(3)));
      end

      drain();
      repeat (SETTLE) @(posedge clock);
      $display("%0d requests over %0d window writes, %0d results checked, %0d mismatches",
               requests_sent, window_writes, checked, mismatches);
      $display("covered zero time, full table, expiry at window 0/1/max, repeated rollovers");
      if (mismatches == 0) begin
         $display("tb_sliding_window_frame_rate_meter passed");
      end else begin
         $display("tb_sliding_window_frame_rate_meter failed");
      end
      $finish;
   end

endmodule
